@@ rtl/npns_pkg.sv @@
// Shared widths, register indexes and reset values for the nearest pose node search.
// No dependencies; every other file of the block imports it.
`default_nettype none

package npns_pkg;

    // Input field widths
    localparam int COORD_BITS  = 24;
    localparam int INDEX_BITS  = 16;
    localparam int TRAVEL_BITS = 32;

    // Coordinate difference magnitude, its square and its floor square root
    localparam int MAG_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS   = 2 * MAG_BITS;
    localparam int ROOT_BITS = MAG_BITS;
    localparam int DIST_BITS = 50;

    // Configuration port
    localparam int LIMIT_BITS    = 24;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NODE_DISTANCE_LIMIT = 1'b0,
        CFG_TRAVEL_GAP_LIMIT    = 1'b1
    } t_cfg_index;

    localparam logic [LIMIT_BITS-1:0]  NODE_DISTANCE_LIMIT_RST = LIMIT_BITS'(5000);
    localparam logic [TRAVEL_BITS-1:0] TRAVEL_GAP_LIMIT_RST    = TRAVEL_BITS'(10000);

endpackage

`default_nettype wire

@@ rtl/npns_node_if.sv @@
// Input channel of the node search: one pose graph node per beat.
// Depends on npns_pkg for field widths.
`default_nettype none

interface npns_node_if import npns_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] node_x;
    logic signed [COORD_BITS-1:0] node_y;
    logic [INDEX_BITS-1:0]        map_index;
    logic [INDEX_BITS-1:0]        node_index;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic [TRAVEL_BITS-1:0]       total_travel;
    logic                         first_node;
    logic                         last_node;

    modport source (
        output valid, node_x, node_y, map_index, node_index,
               query_x, query_y, total_travel, first_node, last_node,
        input  ready
    );

    modport sink (
        input  valid, node_x, node_y, map_index, node_index,
               query_x, query_y, total_travel, first_node, last_node,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/npns_result_if.sv @@
// Output channel of the node search: one search result per beat.
// Depends on npns_pkg for field widths.
`default_nettype none

interface npns_result_if import npns_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [INDEX_BITS-1:0] best_map;
    logic [INDEX_BITS-1:0] best_node;
    logic [DIST_BITS-1:0]  best_distance_sq;

    modport source (
        output valid, found, best_map, best_node, best_distance_sq,
        input  ready
    );

    modport sink (
        input  valid, found, best_map, best_node, best_distance_sq,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/npns_sqdist.sv @@
// Squared distances: step length squared, query distance squared, limit squared.
// One shared MAG_BITS x MAG_BITS squarer, one operand per cycle. Depends on npns_pkg.
`default_nettype none

module npns_sqdist import npns_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic signed [COORD_BITS-1:0] i_node_x,
    input  wire logic signed [COORD_BITS-1:0] i_node_y,
    input  wire logic signed [COORD_BITS-1:0] i_prev_x,
    input  wire logic signed [COORD_BITS-1:0] i_prev_y,
    input  wire logic signed [COORD_BITS-1:0] i_query_x,
    input  wire logic signed [COORD_BITS-1:0] i_query_y,
    input  wire logic [LIMIT_BITS-1:0]        i_limit,
    output logic                              o_done,
    output logic [SQ_BITS-1:0]                o_step_sq,
    output logic [SQ_BITS-1:0]                o_query_sq,
    output logic [SQ_BITS-1:0]                o_limit_sq
);

    // Operand slots, in the order they go through the squarer
    localparam logic [2:0] SLOT_STEP_X  = 3'd0;
    localparam logic [2:0] SLOT_STEP_Y  = 3'd1;
    localparam logic [2:0] SLOT_QUERY_X = 3'd2;
    localparam logic [2:0] SLOT_QUERY_Y = 3'd3;
    localparam logic [2:0] SLOT_LIMIT   = 3'd4;
    localparam logic [2:0] SLOT_END     = 3'd5;

    // |a - b| of two signed coordinates; the magnitude always fits MAG_BITS
    function automatic logic [MAG_BITS-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic [MAG_BITS-1:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        return d[MAG_BITS-1] ? (~d + MAG_BITS'(1)) : d;
    endfunction

    logic                r_busy;
    logic                r_done;
    logic [2:0]          r_cnt;
    logic [MAG_BITS-1:0] r_mag_sx;
    logic [MAG_BITS-1:0] r_mag_sy;
    logic [MAG_BITS-1:0] r_mag_qx;
    logic [MAG_BITS-1:0] r_mag_qy;
    logic [MAG_BITS-1:0] r_mag_lim;
    logic [SQ_BITS-1:0]  r_prod;
    logic [SQ_BITS-1:0]  r_step_sq;
    logic [SQ_BITS-1:0]  r_query_sq;
    logic [SQ_BITS-1:0]  r_limit_sq;

    logic [MAG_BITS-1:0] w_sel;
    logic [SQ_BITS-1:0]  w_prod;

    // Squarer operand select
    always_comb begin
        case (r_cnt)
            SLOT_STEP_X:  w_sel = r_mag_sx;
            SLOT_STEP_Y:  w_sel = r_mag_sy;
            SLOT_QUERY_X: w_sel = r_mag_qx;
            SLOT_QUERY_Y: w_sel = r_mag_qy;
            default:      w_sel = r_mag_lim;
        endcase
    end

    assign w_prod = {{MAG_BITS{1'b0}}, w_sel} * {{MAG_BITS{1'b0}}, w_sel};

    // Square one slot per cycle, accumulate the product of the slot before
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= SLOT_STEP_X;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_cnt     <= SLOT_STEP_X;
                r_mag_sx  <= abs_diff(i_node_x, i_prev_x);
                r_mag_sy  <= abs_diff(i_node_y, i_prev_y);
                r_mag_qx  <= abs_diff(i_node_x, i_query_x);
                r_mag_qy  <= abs_diff(i_node_y, i_query_y);
                r_mag_lim <= {1'b0, i_limit};
            end else if (r_busy) begin
                if (r_cnt != SLOT_END) begin
                    r_prod <= w_prod;
                end
                case (r_cnt)
                    SLOT_STEP_Y:  r_step_sq  <= r_prod;
                    SLOT_QUERY_X: r_step_sq  <= r_step_sq + r_prod;
                    SLOT_QUERY_Y: r_query_sq <= r_prod;
                    SLOT_LIMIT:   r_query_sq <= r_query_sq + r_prod;
                    SLOT_END: begin
                        r_limit_sq <= r_prod;
                        r_busy     <= 1'b0;
                        r_done     <= 1'b1;
                    end
                    default: ;
                endcase
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    assign o_done     = r_done;
    assign o_step_sq  = r_step_sq;
    assign o_query_sq = r_query_sq;
    assign o_limit_sq = r_limit_sq;

endmodule

`default_nettype wire

@@ rtl/npns_sqrt.sv @@
// Digit-serial floor square root: two radicand bits in, one root bit out per cycle.
// Restoring method on a shift register. Depends on npns_pkg.
`default_nettype none

module npns_sqrt import npns_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [SQ_BITS-1:0]   i_radicand,
    output logic                      o_done,
    output logic [ROOT_BITS-1:0]      o_root
);

    localparam int REM_BITS   = ROOT_BITS + 1;
    localparam int TRIAL_BITS = REM_BITS + 2;
    localparam int CNT_BITS   = $clog2(ROOT_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(ROOT_BITS - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [SQ_BITS-1:0]   r_rad;
    logic [ROOT_BITS-1:0] r_root;
    logic [REM_BITS-1:0]  r_rem;

    logic [TRIAL_BITS-1:0] w_trial;
    logic [TRIAL_BITS-1:0] w_sub;
    logic [TRIAL_BITS-1:0] w_diff;
    logic                  w_ge;

    // Trial subtract of (4*root + 1) from the remainder with the next two bits
    assign w_trial = {r_rem, r_rad[SQ_BITS-1 -: 2]};
    assign w_sub   = {1'b0, r_root, 2'b01};
    assign w_diff  = w_trial - w_sub;
    assign w_ge    = (w_trial >= w_sub);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_radicand;
                r_root <= '0;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rad <= {r_rad[SQ_BITS-3:0], 2'b00};
                if (w_ge) begin
                    r_rem  <= w_diff[REM_BITS-1:0];
                    r_root <= {r_root[ROOT_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= w_trial[REM_BITS-1:0];
                    r_root <= {r_root[ROOT_BITS-2:0], 1'b0};
                end
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + CNT_BITS'(1);
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

@@ rtl/nearest_pose_node_search_top.sv @@
// Nearest pose node search: node channel in, result channel out, config write port.
// Depends on npns_pkg, npns_node_if, npns_result_if, npns_sqdist and npns_sqrt.
//
// Nodes arrive one per beat in travel order; first_node opens a search and latches the
// query pose and total travel, last_node makes one result beat follow. The block works
// on one node at a time: a node that is still searched goes from accept to the next
// accept by taking the beat, the shared squarer (load plus one pass per operand slot),
// starting the root, the step length square root (load plus one iteration per root
// bit), and updating travel, deciding and finishing. Once the travel cutoff has stopped a
// search, each further node goes straight to the finish step. A finished result waits in an
// output register, so the next node is taken while it is not yet collected; a second
// last node holds in its finish cycle until that register frees up. Configuration
// writes are taken in any cycle.
`default_nettype none

module nearest_pose_node_search_top import npns_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    npns_node_if.sink                      i_node,
    npns_result_if.source                  o_result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_DECIDE,
        ST_FINISH
    } t_state;

    t_state                       r_state;
    logic [LIMIT_BITS-1:0]        r_node_distance_limit;
    logic [TRAVEL_BITS-1:0]       r_travel_gap_limit;

    // Current node
    logic signed [COORD_BITS-1:0] r_node_x;
    logic signed [COORD_BITS-1:0] r_node_y;
    logic [INDEX_BITS-1:0]        r_map_index;
    logic [INDEX_BITS-1:0]        r_node_index;
    logic                         r_last;

    // Search state
    logic signed [COORD_BITS-1:0] r_prev_x;
    logic signed [COORD_BITS-1:0] r_prev_y;
    logic signed [COORD_BITS-1:0] r_query_x;
    logic signed [COORD_BITS-1:0] r_query_y;
    logic [TRAVEL_BITS-1:0]       r_total;
    logic [TRAVEL_BITS-1:0]       r_travel;
    logic [SQ_BITS-1:0]           r_best_sq;
    logic [INDEX_BITS-1:0]        r_best_map;
    logic [INDEX_BITS-1:0]        r_best_node;
    logic                         r_found;
    logic                         r_stopped;
    logic                         r_seed;

    // Unit starts
    logic                         r_sq_start;
    logic                         r_rt_start;

    // Output register
    logic                         r_out_valid;
    logic                         r_out_found;
    logic [INDEX_BITS-1:0]        r_out_map;
    logic [INDEX_BITS-1:0]        r_out_node;
    logic [DIST_BITS-1:0]         r_out_dist;

    logic                         w_sq_done;
    logic [SQ_BITS-1:0]           w_step_sq;
    logic [SQ_BITS-1:0]           w_query_sq;
    logic [SQ_BITS-1:0]           w_limit_sq;
    logic                         w_rt_done;
    logic [ROOT_BITS-1:0]         w_root;

    logic                         w_in_beat;
    logic                         w_out_beat;
    logic                         w_out_load;
    logic                         w_skip;
    logic [TRAVEL_BITS:0]         w_travel_sum;
    logic [TRAVEL_BITS-1:0]       w_travel_sat;
    logic [TRAVEL_BITS-1:0]       w_remaining;
    logic                         w_cutoff;

    npns_sqdist u_sqdist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sq_start),
        .i_node_x   (r_node_x),
        .i_node_y   (r_node_y),
        .i_prev_x   (r_prev_x),
        .i_prev_y   (r_prev_y),
        .i_query_x  (r_query_x),
        .i_query_y  (r_query_y),
        .i_limit    (r_node_distance_limit),
        .o_done     (w_sq_done),
        .o_step_sq  (w_step_sq),
        .o_query_sq (w_query_sq),
        .o_limit_sq (w_limit_sq)
    );

    npns_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_rt_start),
        .i_radicand (w_step_sq),
        .o_done     (w_rt_done),
        .o_root     (w_root)
    );

    assign w_in_beat  = i_node.valid && i_node.ready;
    assign w_out_beat = r_out_valid && o_result.ready;

    // A last node loads the output register once it is free or being collected
    assign w_out_load = (r_state == ST_FINISH) && r_last && (!r_out_valid || o_result.ready);

    // A stopped search skips the node unless this beat opens a new search
    assign w_skip = r_stopped && !i_node.first_node;

    // Travel sum, saturating
    assign w_travel_sum = {1'b0, r_travel} + (TRAVEL_BITS + 1)'(w_root);
    assign w_travel_sat = w_travel_sum[TRAVEL_BITS] ? '1 : w_travel_sum[TRAVEL_BITS-1:0];

    // Remaining travel below the gap, or travel past the total, stops the search
    assign w_remaining = r_total - r_travel;
    assign w_cutoff    = (r_travel > r_total) || (w_remaining < r_travel_gap_limit);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_distance_limit <= NODE_DISTANCE_LIMIT_RST;
            r_travel_gap_limit    <= TRAVEL_GAP_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_NODE_DISTANCE_LIMIT:
                    r_node_distance_limit <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_TRAVEL_GAP_LIMIT:
                    r_travel_gap_limit <= i_cfg_data[TRAVEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Search sequencer, search state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_query_x   <= '0;
            r_query_y   <= '0;
            r_total     <= '0;
            r_travel    <= '0;
            r_best_sq   <= '0;
            r_best_map  <= '0;
            r_best_node <= '0;
            r_found     <= 1'b0;
            r_stopped   <= 1'b0;
            r_seed      <= 1'b0;
            r_sq_start  <= 1'b0;
            r_rt_start  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_beat) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_beat) begin
                        r_node_x     <= i_node.node_x;
                        r_node_y     <= i_node.node_y;
                        r_map_index  <= i_node.map_index;
                        r_node_index <= i_node.node_index;
                        r_last       <= i_node.last_node;
                        // New search: latch the query, seed previous with this node
                        if (i_node.first_node) begin
                            r_query_x   <= i_node.query_x;
                            r_query_y   <= i_node.query_y;
                            r_total     <= i_node.total_travel;
                            r_prev_x    <= i_node.node_x;
                            r_prev_y    <= i_node.node_y;
                            r_travel    <= '0;
                            r_best_map  <= '0;
                            r_best_node <= '0;
                            r_found     <= 1'b0;
                            r_stopped   <= 1'b0;
                            r_seed      <= 1'b1;
                        end
                        if (w_skip) begin
                            r_state <= ST_FINISH;
                        end else begin
                            r_sq_start <= 1'b1;
                            r_state    <= ST_SQUARE;
                        end
                    end
                end
                ST_SQUARE: begin
                    r_sq_start <= 1'b0;
                    if (w_sq_done) begin
                        // Best distance starts at the limit squared
                        if (r_seed) begin
                            r_best_sq <= w_limit_sq;
                            r_seed    <= 1'b0;
                        end
                        r_rt_start <= 1'b1;
                        r_state    <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    r_rt_start <= 1'b0;
                    if (w_rt_done) begin
                        r_travel <= w_travel_sat;
                        r_prev_x <= r_node_x;
                        r_prev_y <= r_node_y;
                        r_state  <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (w_cutoff) begin
                        r_stopped <= 1'b1;
                    end else if (w_query_sq < r_best_sq) begin
                        r_best_sq   <= w_query_sq;
                        r_best_map  <= r_map_index;
                        r_best_node <= r_node_index;
                        r_found     <= 1'b1;
                    end
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (!r_last) begin
                        r_state <= ST_IDLE;
                    end else if (w_out_load) begin
                        r_out_found <= r_found;
                        r_out_map   <= r_found ? r_best_map : '0;
                        r_out_node  <= r_found ? r_best_node : '0;
                        r_out_dist  <= r_found ? r_best_sq[DIST_BITS-1:0] : '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_node.ready              = (r_state == ST_IDLE);
    assign o_result.valid            = r_out_valid;
    assign o_result.found            = r_out_found;
    assign o_result.best_map         = r_out_map;
    assign o_result.best_node        = r_out_node;
    assign o_result.best_distance_sq = r_out_dist;

endmodule

`default_nettype wire
